// File: rtl/icr_pkg.sv
// shared types, constants and table functions for the incidence colour ramp
package icr_pkg;

    localparam int MAX_STOPS_DEF  = 16;
    localparam int ACOS_DEPTH_DEF = 1024;
    localparam int QUEUE_DEPTH    = 4;
    localparam int LANES          = 4;
    localparam int QUO_W          = 8;
    localparam int NUM_W          = 25;
    localparam int CFG_IDX_W      = 1;
    localparam int CFG_DATA_W     = 5;
    localparam int CORDIC_STEPS   = 18;
    localparam int ANGLE_MAX_Q88  = 23040;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_SHADE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_STOPS_IN_USE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT       = 1'b1;

    localparam longint ATAN_DEG_Q16 [CORDIC_STEPS] = '{
        2949120, 1740967, 919879, 466945, 234379, 117267, 58666, 29335, 14668,
        7334, 3667, 1833, 917, 458, 229, 115, 57, 29
    };

    typedef struct packed {
        logic              kind;
        logic [3:0]        stop_index;
        logic [15:0]       stop_key;
        logic [23:0]       stop_rgb;
        logic [7:0]        stop_alpha;
        logic              stop_mode;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic signed [15:0] ray_dir_x;
        logic signed [15:0] ray_dir_y;
        logic signed [15:0] ray_dir_z;
    } t_in_item;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } t_out_item;

    typedef struct packed {
        logic        kind;
        logic [3:0]  stop_index;
        logic [15:0] stop_key;
        logic [23:0] stop_rgb;
        logic [7:0]  stop_alpha;
        logic        stop_mode;
    } t_load;

    typedef struct packed {
        logic [15:0] key;
        logic [23:0] rgb;
        logic [7:0]  alpha;
        logic        mode;
    } t_stop;

    typedef struct packed {
        logic [7:0]       base;
        logic             neg;
        logic [NUM_W-1:0] num;
    } t_lane;

    typedef struct packed {
        t_lane [LANES-1:0] lanes;
        logic [15:0]       den;
    } t_job;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_HOLD
    } t_back_state;

    function automatic longint unsigned udiv64(input longint unsigned num,
                                               input longint unsigned den);
        longint unsigned rem;
        longint unsigned quo;
        rem = 0;
        quo = 0;
        for (int b = 63; b >= 0; b--) begin
            rem = (rem << 1) | ((num >> b) & 64'd1);
            if (rem >= den) begin
                rem = rem - den;
                quo = quo | (64'd1 << b);
            end
        end
        return quo;
    endfunction

    function automatic longint unsigned isqrt64(input longint unsigned v_in);
        longint unsigned v;
        longint unsigned res;
        longint unsigned bit_w;
        v = v_in;
        res = 0;
        bit_w = 64'd1 << 62;
        while (bit_w > v) bit_w = bit_w >> 2;
        while (bit_w != 0) begin
            if (v >= res + bit_w) begin
                v = v - (res + bit_w);
                res = (res >> 1) + bit_w;
            end else begin
                res = res >> 1;
            end
            bit_w = bit_w >> 2;
        end
        return res;
    endfunction

    function automatic logic [15:0] acos_entry(input int i, input int depth);
        longint unsigned den;
        longint unsigned xu;
        longint x;
        longint y;
        longint z;
        longint xs;
        longint ys;
        den = longint'(depth - 1);
        xu = udiv64((longint'(i) << 28) + (den >> 1), den);
        if (xu > (64'd1 << 28)) xu = 64'd1 << 28;
        x = longint'(xu);
        y = longint'(isqrt64((64'd1 << 56) - xu * xu));
        z = 0;
        for (int k = 0; k < CORDIC_STEPS; k++) begin
            xs = x >>> k;
            ys = y >>> k;
            if (y > 0) begin
                x = x + ys;
                y = y - xs;
                z = z + ATAN_DEG_Q16[k];
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - ATAN_DEG_Q16[k];
            end
        end
        z = (z + 128) >>> 8;
        if (z < 0) z = 0;
        if (z > ANGLE_MAX_Q88) z = ANGLE_MAX_Q88;
        return 16'(z);
    endfunction

endpackage

// File: rtl/icr_if.sv
// stream channels of the incidence colour ramp
interface icr_in_if;
    logic              valid;
    logic              ready;
    icr_pkg::t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface icr_out_if;
    logic               valid;
    logic               ready;
    icr_pkg::t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: rtl/icr_front.sv
// front pipeline: dot product, acos lookup, stop search, stop storage, job forming
module icr_front #(
    parameter int MAX_STOPS       = icr_pkg::MAX_STOPS_DEF,
    parameter int ACOS_TABLE_DEPTH = icr_pkg::ACOS_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  icr_pkg::t_in_item                 i_item,
    input  logic [icr_pkg::CFG_DATA_W-1:0]    i_stops_in_use,
    output logic                              o_push,
    output icr_pkg::t_job                     o_job,
    input  logic                              i_full
);
    import icr_pkg::*;

    localparam int SW = (MAX_STOPS > 1) ? $clog2(MAX_STOPS) : 1;
    localparam int CW = $clog2(MAX_STOPS + 1);
    localparam int TW = $clog2(ACOS_TABLE_DEPTH);
    localparam int PW = 29 + TW + 1;
    localparam logic [28:0] ONE_Q28 = 29'h1000_0000;

    typedef logic [15:0] t_rom [ACOS_TABLE_DEPTH];

    function automatic t_rom build_rom();
        t_rom r;
        for (int i = 0; i < ACOS_TABLE_DEPTH; i++) r[i] = acos_entry(i, ACOS_TABLE_DEPTH);
        return r;
    endfunction

    localparam t_rom ACOS_ROM = build_rom();

    function automatic t_lane make_lane(input logic [7:0] lo, input logic [7:0] hi,
                                        input logic [15:0] t, input logic [15:0] den,
                                        input logic dir);
        t_lane l;
        logic [7:0] diff;
        diff = (hi >= lo) ? (hi - lo) : (lo - hi);
        l.base = lo;
        l.neg = (hi < lo);
        l.num = NUM_W'(diff) * NUM_W'({t, 1'b0}) + NUM_W'(den);
        if (dir) begin
            l.base = hi;
            l.neg = 1'b0;
            l.num = '0;
        end
        return l;
    endfunction

    logic               adv;
    logic               r_a_v, r_b_v, r_c_v, r_d_v;
    t_load              r_a_ld, r_b_ld, r_c_ld;
    logic signed [31:0] r_a_px, r_a_py, r_a_pz;
    logic [TW-1:0]      r_b_idx;
    logic [15:0]        r_c_angle;
    logic               r_d_shade;
    logic [15:0]        r_d_angle;
    logic               r_d_direct;
    t_stop              r_d_lo, r_d_hi;

    logic [15:0]        r_key [MAX_STOPS];
    t_stop              r_mem [MAX_STOPS];

    logic signed [33:0] dot;
    logic [33:0]        mag_full;
    logic [28:0]        mag;
    logic [PW-1:0]      prod;

    logic [CW-1:0]      count;
    logic [CW-1:0]      j;
    logic               direct;
    logic [CW-1:0]      sel;
    logic [SW-1:0]      lo_addr, hi_addr;
    logic               load_we;
    t_in_item           in_item;

    logic [15:0]        t_val, den_val;
    logic               dir_fin;

    assign in_item = i_item;
    assign adv = !r_d_v || !r_d_shade || !i_full;
    assign o_ready = adv;
    assign o_push = r_d_v && r_d_shade && !i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
        end else if (adv) begin
            r_a_v <= i_valid;
            r_b_v <= r_a_v;
            r_c_v <= r_b_v;
            r_d_v <= r_c_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a_ld <= '{kind: in_item.kind, stop_index: in_item.stop_index,
                        stop_key: in_item.stop_key, stop_rgb: in_item.stop_rgb,
                        stop_alpha: in_item.stop_alpha, stop_mode: in_item.stop_mode};
            r_a_px <= in_item.normal_x * in_item.ray_dir_x;
            r_a_py <= in_item.normal_y * in_item.ray_dir_y;
            r_a_pz <= in_item.normal_z * in_item.ray_dir_z;
            r_b_ld <= r_a_ld;
            r_b_idx <= TW'(prod >> 28);
            r_c_ld <= r_b_ld;
            r_c_angle <= ACOS_ROM[r_b_idx];
            r_d_shade <= (r_c_ld.kind == KIND_SHADE);
            r_d_angle <= r_c_angle;
            r_d_direct <= direct;
        end
    end

    // saturated dot magnitude to table index
    always_comb begin
        dot = 34'(r_a_px) + 34'(r_a_py) + 34'(r_a_pz);
        mag_full = dot[33] ? 34'(-dot) : 34'(dot);
        mag = (mag_full > 34'(ONE_Q28)) ? ONE_Q28 : 29'(mag_full);
        prod = PW'(mag) * PW'(ACOS_TABLE_DEPTH - 1) + (PW'(1) << 27);
    end

    // first stop above the angle
    always_comb begin
        if (i_stops_in_use == '0) begin
            count = CW'(1);
        end else if (int'(i_stops_in_use) > MAX_STOPS) begin
            count = CW'(MAX_STOPS);
        end else begin
            count = CW'(i_stops_in_use);
        end
        j = count;
        for (int i = MAX_STOPS - 1; i >= 0; i--) begin
            if ((CW'(i) < count) && (r_key[i] > r_c_angle)) j = CW'(i);
        end
        direct = (j == '0) || (j == count);
        if (j == '0) begin
            sel = '0;
        end else if (j == count) begin
            sel = count - CW'(1);
        end else begin
            sel = j;
        end
        hi_addr = SW'(sel);
        lo_addr = direct ? SW'(sel) : SW'(j - CW'(1));
        load_we = adv && r_c_v && (r_c_ld.kind == KIND_LOAD) &&
                  (int'(r_c_ld.stop_index) < MAX_STOPS);
    end

    always_ff @(posedge i_clk) begin
        if (load_we) begin
            r_key[SW'(r_c_ld.stop_index)] <= r_c_ld.stop_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_we) begin
            r_mem[SW'(r_c_ld.stop_index)] <= '{key: r_c_ld.stop_key, rgb: r_c_ld.stop_rgb,
                                               alpha: r_c_ld.stop_alpha,
                                               mode: r_c_ld.stop_mode};
        end
        if (adv) begin
            r_d_lo <= r_mem[lo_addr];
            r_d_hi <= r_mem[hi_addr];
        end
    end

    always_comb begin
        t_val = r_d_angle - r_d_lo.key;
        den_val = r_d_hi.key - r_d_lo.key;
        dir_fin = r_d_direct || r_d_hi.mode || (den_val == '0);
        o_job.lanes[0] = make_lane(r_d_lo.rgb[23:16], r_d_hi.rgb[23:16], t_val, den_val,
                                   dir_fin);
        o_job.lanes[1] = make_lane(r_d_lo.rgb[15:8], r_d_hi.rgb[15:8], t_val, den_val,
                                   dir_fin);
        o_job.lanes[2] = make_lane(r_d_lo.rgb[7:0], r_d_hi.rgb[7:0], t_val, den_val, dir_fin);
        o_job.lanes[3] = make_lane(r_d_lo.alpha, r_d_hi.alpha, t_val, den_val, dir_fin);
        o_job.den = dir_fin ? 16'd1 : den_val;
    end

endmodule

// File: rtl/icr_queue.sv
// job queue between front and back
module icr_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  icr_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output icr_pkg::t_job o_job,
    output logic          o_empty
);
    import icr_pkg::*;

    localparam int QAW = $clog2(QUEUE_DEPTH);

    t_job           r_slot [QUEUE_DEPTH];
    logic [QAW-1:0] r_wr, r_rd;
    logic [QAW:0]   r_cnt;

    assign o_full = (r_cnt == (QAW + 1)'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job = r_slot[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop) r_rd <= r_rd + 1'b1;
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_slot[r_wr] <= i_job;
    end

endmodule

// File: rtl/icr_back.sv
// back end: four-lane bit-serial divider for the ramp blend, output register
module icr_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_empty,
    output logic               o_pop,
    input  icr_pkg::t_job      i_job,
    input  logic               i_invert,
    output logic               o_valid,
    input  logic               i_ready,
    output icr_pkg::t_out_item o_item
);
    import icr_pkg::*;

    localparam int SCW = $clog2(QUO_W);

    t_back_state      r_state, n_state;
    logic             step, load_out;
    logic [SCW-1:0]   r_step;
    logic [NUM_W-1:0] r_rem [LANES];
    logic [QUO_W-1:0] r_q [LANES];
    logic [7:0]       r_base [LANES];
    logic             r_neg [LANES];
    logic [NUM_W-1:0] r_dsh;
    logic             r_out_v;
    t_out_item        r_out;
    logic [7:0]       res [LANES];

    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (!i_empty) n_state = BK_DIV;
            end
            BK_DIV: begin
                if (r_step == SCW'(QUO_W - 1)) n_state = BK_HOLD;
            end
            BK_HOLD: begin
                if (!r_out_v || i_ready) n_state = BK_IDLE;
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        o_pop = 1'b0;
        step = 1'b0;
        load_out = 1'b0;
        case (r_state)
            BK_IDLE: o_pop = !i_empty;
            BK_DIV: step = 1'b1;
            BK_HOLD: load_out = !r_out_v || i_ready;
            default: o_pop = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
            r_out_v <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_out_v <= 1'b1;
            end else if (i_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_step <= '0;
            r_dsh <= NUM_W'({i_job.den, 8'd0});
            for (int i = 0; i < LANES; i++) begin
                r_rem[i] <= i_job.lanes[i].num;
                r_base[i] <= i_job.lanes[i].base;
                r_neg[i] <= i_job.lanes[i].neg;
                r_q[i] <= '0;
            end
        end else if (step) begin
            r_step <= r_step + 1'b1;
            r_dsh <= r_dsh >> 1;
            for (int i = 0; i < LANES; i++) begin
                if (r_rem[i] >= r_dsh) begin
                    r_rem[i] <= r_rem[i] - r_dsh;
                    r_q[i] <= {r_q[i][QUO_W-2:0], 1'b1};
                end else begin
                    r_q[i] <= {r_q[i][QUO_W-2:0], 1'b0};
                end
            end
        end
    end

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            res[i] = r_neg[i] ? (r_base[i] - r_q[i]) : (r_base[i] + r_q[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out.red <= i_invert ? (8'hFF - res[0]) : res[0];
            r_out.green <= i_invert ? (8'hFF - res[1]) : res[1];
            r_out.blue <= i_invert ? (8'hFF - res[2]) : res[2];
            r_out.alpha <= res[3];
        end
    end

    assign o_valid = r_out_v;
    assign o_item = r_out;

endmodule

// File: rtl/incidence_colour_ramp.sv
// top level of the incidence colour ramp
//  channel   | dir | handshake     | payload
//  i_item    | in  | valid / ready | load or shade item (t_in_item)
//  o_result  | out | valid / ready | red, green, blue, alpha (t_out_item)
//  i_cfg_*   | in  | write enable  | stops_in_use, invert_colour
// a load transfer never reaches the back end; a shade item is paced in the back end
// by the 8-step divider shared by the four channel lanes
// the front registers stages a, b, c and d; a 4-deep job queue lets the front keep taking items
// synchronous active-low reset clears control and config only; stop stores hold no reset
// output stalls back up through the queue to i_item.ready
module incidence_colour_ramp #(
    parameter int MAX_STOPS        = icr_pkg::MAX_STOPS_DEF,
    parameter int ACOS_TABLE_DEPTH = icr_pkg::ACOS_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    icr_in_if.sink                         i_item,
    icr_out_if.source                      o_result,
    input  logic                           i_cfg_we,
    input  logic [icr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [icr_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import icr_pkg::*;

    logic [CFG_DATA_W-1:0] r_stops_in_use;
    logic                  r_invert;
    logic                  push, full, pop, empty;
    t_job                  job_in, job_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stops_in_use <= CFG_DATA_W'(1);
            r_invert <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_STOPS_IN_USE: r_stops_in_use <= i_cfg_data;
                CFG_INVERT: r_invert <= i_cfg_data[0];
                default: r_invert <= r_invert;
            endcase
        end
    end

    icr_front #(
        .MAX_STOPS(MAX_STOPS),
        .ACOS_TABLE_DEPTH(ACOS_TABLE_DEPTH)
    ) u_front (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_item.valid),
        .o_ready(i_item.ready),
        .i_item(i_item.data),
        .i_stops_in_use(r_stops_in_use),
        .o_push(push),
        .o_job(job_in),
        .i_full(full)
    );

    icr_queue u_queue (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_push(push),
        .i_job(job_in),
        .o_full(full),
        .i_pop(pop),
        .o_job(job_out),
        .o_empty(empty)
    );

    icr_back u_back (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_empty(empty),
        .o_pop(pop),
        .i_job(job_out),
        .i_invert(r_invert),
        .o_valid(o_result.valid),
        .i_ready(o_result.ready),
        .o_item(o_result.data)
    );

endmodule

// File: rtl/icr_checker.sv
// port-level checks for the incidence colour ramp, bound to the top level
module icr_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_in_kind,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input icr_pkg::t_out_item i_out_data
);
    import icr_pkg::*;

    logic [7:0] r_pend;

    // shade items taken but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= r_pend + 8'(i_in_valid && i_in_ready && (i_in_kind == KIND_SHADE))
                             - 8'(i_out_valid && i_out_ready);
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_data))
        else $error("result changed while stalled");

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_pend != 8'd0)
        else $error("result without a pending shade item");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind incidence_colour_ramp icr_checker u_icr_checker (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .i_in_valid(i_item.valid),
    .i_in_ready(i_item.ready),
    .i_in_kind(i_item.data.kind),
    .i_out_valid(o_result.valid),
    .i_out_ready(o_result.ready),
    .i_out_data(o_result.data)
);

// File: tb/sv/tb.sv
// self-checking testbench of the incidence colour ramp: directed table, then random phases
`timescale 1ns / 1ps

module tb;
    import icr_pkg::*;

    localparam int N_STOPS    = 16;
    localparam int LUT_DEPTH  = 1024;
    localparam int IDLE_LIMIT = 3000;
    localparam int SETTLE     = 30;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_op;

    typedef struct {
        t_row_op                 op;
        t_in_item                item;
        bit                      typed;
        t_out_item               want;
        logic [CFG_IDX_W-1:0]    cfg_idx;
        logic [CFG_DATA_W-1:0]   cfg_data;
    } t_row;

    typedef struct {
        bit        typed;
        t_out_item want;
    } t_typed;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    icr_in_if  item_ch ();
    icr_out_if result_ch ();

    incidence_colour_ramp i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (item_ch.sink),
        .o_result   (result_ch.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    logic [15:0] incidence_lut [LUT_DEPTH];
    logic [15:0] ramp_key [N_STOPS];
    logic [23:0] ramp_rgb [N_STOPS];
    logic [7:0]  ramp_alpha [N_STOPS];
    logic        ramp_mode [N_STOPS];
    logic [4:0]  ramp_count;
    logic        ramp_invert;

    t_out_item colour_q [$];
    t_typed    typed_q [$];
    t_row      rows [$];

    int  errors;
    int  n_in;
    int  n_loads;
    int  n_shades;
    int  n_out;
    int  n_cfg;
    int  idle_cycles;
    bit  steady;
    bit  held;

    localparam longint ATAN_Q16 [18] = '{
        2949120, 1740967, 919879, 466945, 234379, 117267, 58666, 29335, 14668,
        7334, 3667, 1833, 917, 458, 229, 115, 57, 29
    };

    function automatic longint unsigned root_floor(input longint unsigned v);
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        lo = 0;
        hi = 64'd1 << 28;
        while (lo < hi) begin
            mid = (lo + hi + 1) >> 1;
            if (mid * mid <= v) lo = mid;
            else hi = mid - 1;
        end
        return lo;
    endfunction

    function automatic logic [15:0] angle_of(input int i);
        longint unsigned xu;
        longint x;
        longint y;
        longint z;
        longint xs;
        longint ys;
        xu = ((longint'(i) << 28) + (LUT_DEPTH - 1) / 2) / (LUT_DEPTH - 1);
        if (xu > (64'd1 << 28)) xu = 64'd1 << 28;
        x = longint'(xu);
        y = longint'(root_floor((64'd1 << 56) - xu * xu));
        z = 0;
        for (int k = 0; k < 18; k++) begin
            xs = x >>> k;
            ys = y >>> k;
            if (y > 0) begin
                x = x + ys;
                y = y - xs;
                z = z + ATAN_Q16[k];
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - ATAN_Q16[k];
            end
        end
        z = (z + 128) >>> 8;
        if (z < 0) z = 0;
        if (z > 23040) z = 23040;
        return 16'(z);
    endfunction

    function automatic logic [7:0] blend(input int unsigned lo, input int unsigned hi,
                                         input int unsigned t, input int unsigned den);
        if (den == 0) return 8'(lo);
        if (hi >= lo) return 8'(lo + ((hi - lo) * t * 2 + den) / (2 * den));
        return 8'(lo - ((lo - hi) * t * 2 + den) / (2 * den));
    endfunction

    function automatic t_out_item shade_colour(input t_in_item it);
        t_out_item   r;
        longint      dot;
        longint      mag;
        longint      idx;
        int unsigned angle;
        int unsigned cnt;
        int unsigned j;
        int unsigned s;
        int unsigned t;
        int unsigned den;
        dot = longint'(it.normal_x) * longint'(it.ray_dir_x)
            + longint'(it.normal_y) * longint'(it.ray_dir_y)
            + longint'(it.normal_z) * longint'(it.ray_dir_z);
        mag = dot < 0 ? -dot : dot;
        if (mag > (64'sd1 <<< 28)) mag = 64'sd1 <<< 28;
        idx = (mag * (LUT_DEPTH - 1) + (64'sd1 <<< 27)) >>> 28;
        if (idx > LUT_DEPTH - 1) idx = LUT_DEPTH - 1;
        angle = incidence_lut[idx];
        cnt = ramp_count == 0 ? 1 : (ramp_count > N_STOPS ? N_STOPS : ramp_count);
        j = cnt;
        for (int k = cnt - 1; k >= 0; k--) begin
            if (ramp_key[k] > angle) j = k;
        end
        if (j == 0 || j == cnt || ramp_mode[j]) begin
            s = j == 0 ? 0 : (j == cnt ? cnt - 1 : j);
            r.red   = ramp_rgb[s][23:16];
            r.green = ramp_rgb[s][15:8];
            r.blue  = ramp_rgb[s][7:0];
            r.alpha = ramp_alpha[s];
        end else begin
            t   = angle - ramp_key[j-1];
            den = ramp_key[j] - ramp_key[j-1];
            r.red   = blend(ramp_rgb[j-1][23:16], ramp_rgb[j][23:16], t, den);
            r.green = blend(ramp_rgb[j-1][15:8], ramp_rgb[j][15:8], t, den);
            r.blue  = blend(ramp_rgb[j-1][7:0], ramp_rgb[j][7:0], t, den);
            r.alpha = blend(ramp_alpha[j-1], ramp_alpha[j], t, den);
        end
        if (ramp_invert) begin
            r.red   = 8'd255 - r.red;
            r.green = 8'd255 - r.green;
            r.blue  = 8'd255 - r.blue;
        end
        return r;
    endfunction

    function automatic t_in_item make_load(input int idx, input int key, input int rgb,
                                           input int alpha, input bit mode);
        t_in_item it;
        it = '0;
        it.kind       = KIND_LOAD;
        it.stop_index = 4'(idx);
        it.stop_key   = 16'(key);
        it.stop_rgb   = 24'(rgb);
        it.stop_alpha = 8'(alpha);
        it.stop_mode  = mode;
        it.normal_x   = 16'($urandom);
        it.ray_dir_z  = 16'($urandom);
        return it;
    endfunction

    function automatic t_in_item make_shade(input int nx, input int ny, input int nz,
                                            input int dx, input int dy, input int dz);
        t_in_item it;
        it = t_in_item'({$urandom, $urandom, $urandom, $urandom});
        it.kind      = KIND_SHADE;
        it.normal_x  = 16'(nx);
        it.normal_y  = 16'(ny);
        it.normal_z  = 16'(nz);
        it.ray_dir_x = 16'(dx);
        it.ray_dir_y = 16'(dy);
        it.ray_dir_z = 16'(dz);
        return it;
    endfunction

    function automatic void item_row(input t_in_item it, input bit typed, input t_out_item w);
        t_row r;
        r.op = ROW_ITEM;
        r.item = it;
        r.typed = typed;
        r.want = w;
        r.cfg_idx = '0;
        r.cfg_data = '0;
        rows.push_back(r);
    endfunction

    function automatic void cfg_row(input logic [CFG_IDX_W-1:0] idx, input int data);
        t_row r;
        r.op = ROW_CFG;
        r.item = '0;
        r.typed = 0;
        r.want = '0;
        r.cfg_idx = idx;
        r.cfg_data = CFG_DATA_W'(data);
        rows.push_back(r);
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic int axis();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return int'($signed(16'($urandom)));
        return int'($urandom_range(0, 32768)) - 16384;
    endfunction

    function automatic int nudge(input int v);
        int r;
        r = v + int'($urandom_range(0, 8000)) - 4000;
        return r > 16384 ? 16384 : (r < -16384 ? -16384 : r);
    endfunction

    task automatic send_item(input t_in_item it);
        int gap;
        item_ch.valid <= 1'b1;
        item_ch.data  <= it;
        do @(posedge i_clk); while (!item_ch.ready);
        gap = pick_gap();
        if (gap > 0) begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_idle();
        item_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (colour_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= d;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic load_ramp();
        int key;
        key = $urandom_range(0, 2000);
        for (int k = 0; k < N_STOPS; k++) begin
            if (k == N_STOPS - 1 && $urandom_range(0, 3) == 0) key = $urandom_range(key, 65535);
            send_item(make_load(k, key, $urandom, $urandom, $urandom_range(0, 9) < 3));
            key = key + $urandom_range(0, 2500);
            if (key > 65535) key = 65535;
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        t_out_item want;
        t_out_item got;
        t_typed    tw;
        if (i_rst_n) begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_STOPS_IN_USE) ramp_count <= i_cfg_data[4:0];
                else if (i_cfg_idx == CFG_INVERT) ramp_invert <= i_cfg_data[0];
            end
            if (item_ch.valid && item_ch.ready) begin
                n_in++;
                if (item_ch.data.kind == KIND_LOAD) begin
                    n_loads++;
                    ramp_key[item_ch.data.stop_index]   <= item_ch.data.stop_key;
                    ramp_rgb[item_ch.data.stop_index]   <= item_ch.data.stop_rgb;
                    ramp_alpha[item_ch.data.stop_index] <= item_ch.data.stop_alpha;
                    ramp_mode[item_ch.data.stop_index]  <= item_ch.data.stop_mode;
                end else begin
                    n_shades++;
                    want = shade_colour(item_ch.data);
                    if (typed_q.size() != 0) begin
                        tw = typed_q.pop_front();
                        if (tw.typed) want = tw.want;
                    end
                    colour_q.push_back(want);
                end
            end
            if (result_ch.valid && result_ch.ready) begin
                n_out++;
                got = result_ch.data;
                if (colour_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result, expected none, got %h", $time, got);
                end else begin
                    want = colour_q.pop_front();
                    check_field("red", want.red, got.red);
                    check_field("green", want.green, got.green);
                    check_field("blue", want.blue, got.blue);
                    check_field("alpha", want.alpha, got.alpha);
                end
            end
            if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles == IDLE_LIMIT) begin
                $display("%0t: timeout, %0d results outstanding", $time, colour_q.size());
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // result side backpressure, with one long hold once traffic is under way
    initial begin
        int r;
        result_ch.ready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            r = $urandom_range(0, 99);
            if (!held && n_in >= 600) begin
                held = 1;
                result_ch.ready <= 1'b0;
                repeat (300) @(posedge i_clk);
            end else if (steady || r < 60) begin
                result_ch.ready <= 1'b1;
                @(posedge i_clk);
            end else if (r < 95) begin
                result_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge i_clk);
            end else begin
                result_ch.ready <= 1'b0;
                repeat ($urandom_range(10, 40)) @(posedge i_clk);
            end
        end
    end

    initial begin
        t_in_item it;
        t_typed   tw;
        int       nx;
        int       ny;
        int       nz;
        int       s;
        int       counts [7] = '{16, 1, 2, 0, 31, 17, 8};

        errors = 0; n_in = 0; n_loads = 0; n_shades = 0; n_out = 0; n_cfg = 0;
        idle_cycles = 0; steady = 0; held = 0;
        ramp_count = 5'd1;
        ramp_invert = 1'b0;
        for (int k = 0; k < N_STOPS; k++) begin
            ramp_key[k] = '0; ramp_rgb[k] = '0; ramp_alpha[k] = '0; ramp_mode[k] = 1'b0;
        end
        for (int i = 0; i < LUT_DEPTH; i++) incidence_lut[i] = angle_of(i);

        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        item_ch.valid = 1'b0;
        item_ch.data = '0;

        // full ramp first, keys ascending, stop 0 white and stop 15 black
        for (int k = 0; k < N_STOPS; k++)
            item_row(make_load(k, k == 0 ? 256 : k * 1500,
                               k == 0 ? 24'hFFFFFF : (k == 15 ? 0 : {8'(k * 16),
                               8'(255 - k * 16), 8'(k * 8)}),
                               k == 0 ? 0 : (k == 15 ? 255 : k * 17), k % 3 == 2 || k == 15),
                     0, '0);
        // single stop in use: every angle gives stop 0
        item_row(make_shade(16384, 0, 0, 16384, 0, 0), 1, 32'hFFFFFF00);
        item_row(make_shade(16384, 0, 0, 0, 16384, 0), 1, 32'hFFFFFF00);
        item_row(make_shade(16384, 16384, 16384, 16384, 16384, 16384), 1, 32'hFFFFFF00);
        item_row(make_shade(-16384, -16384, -16384, 16384, 16384, 16384), 1, 32'hFFFFFF00);
        cfg_row(CFG_INVERT, 1);
        item_row(make_shade(16384, 0, 0, 16384, 0, 0), 1, 32'h00000000);
        cfg_row(CFG_STOPS_IN_USE, 16);
        cfg_row(CFG_INVERT, 0);
        // below the first stop and past the last one, then three more shades checked by shade_colour
        item_row(make_shade(16384, 0, 0, -16384, 0, 0), 1, 32'hFFFFFF00);
        item_row(make_shade(0, 0, 16384, 16384, 0, 0), 1, 32'h000000FF);
        item_row(make_shade(16384, 0, 0, 11585, 11585, 0), 0, '0);
        item_row(make_shade(16384, 0, 0, 8192, 14189, 0), 0, '0);
        item_row(make_shade(-32768, 32767, -32768, -32768, -32768, 32767), 0, '0);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[n]) begin
            if (rows[n].op == ROW_CFG) begin
                wait_idle();
                write_cfg(rows[n].cfg_idx, rows[n].cfg_data);
                n_cfg++;
            end else begin
                if (rows[n].item.kind == KIND_SHADE) begin
                    tw.typed = rows[n].typed;
                    tw.want  = rows[n].want;
                    typed_q.push_back(tw);
                end
                send_item(rows[n].item);
            end
        end

        for (int ph = 0; ph < 12; ph++) begin
            wait_idle();
            write_cfg(CFG_STOPS_IN_USE,
                      CFG_DATA_W'(ph < 7 ? counts[ph] : $urandom_range(0, 31)));
            write_cfg(CFG_INVERT, CFG_DATA_W'(ph < 2 ? ph : $urandom_range(0, 31)));
            n_cfg += 2;
            steady = (ph % 4 == 3);
            if (ph % 3 == 0) load_ramp();
            for (int n = 0; n < 125; n++) begin
                s = $urandom_range(0, 99);
                if (s < 5) begin
                    send_item(make_load($urandom_range(0, 15), $urandom, $urandom, $urandom,
                                        1'($urandom_range(0, 1))));
                end else if (s < 15) begin
                    s = $urandom_range(0, 15);
                    send_item(make_load(s, int'(ramp_key[s]), $urandom, $urandom,
                                        1'($urandom_range(0, 1))));
                end else begin
                    nx = axis(); ny = axis(); nz = axis();
                    if ($urandom_range(0, 9) < 4)
                        it = make_shade(nx, ny, nz, nudge(nx), nudge(ny), nudge(nz));
                    else
                        it = make_shade(nx, ny, nz, axis(), axis(), axis());
                    send_item(it);
                end
            end
        end

        steady = 0;
        item_ch.valid <= 1'b0;
        while (colour_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);

        $display("covered %0d items (%0d stop loads, %0d shades) and %0d register writes",
                 n_in, n_loads, n_shades, n_cfg);
        $display("checked %0d colour results, %0d field mismatches", n_out, errors);
        if (errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
